@@ rtl/hkv_pkg.sv @@
// Package for the hash key-value store: sizes, codes and the bucket hash.
// Used by the core, datapath, controller and checker; depends on nothing.
package hkv_pkg;
  localparam int BUCKET_COUNT = 64;
  localparam int WAYS_PER_BUCKET = 4;
  localparam int VALUE_WIDTH = 32;
  localparam int BUCKET_BITS = $clog2(BUCKET_COUNT);
  localparam int WAY_BITS = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int COUNT_BITS = 9;
  localparam int KEY_BITS = 64;
  localparam int ROW_BITS = WAYS_PER_BUCKET * (KEY_BITS + VALUE_WIDTH);

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  localparam logic [1:0] MODE_U32 = 2'd0;
  localparam logic [1:0] MODE_U64 = 2'd1;
  localparam logic [1:0] MODE_PTR = 2'd2;

  localparam logic [1:0] ST_HIT = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef struct packed {
    logic load;      // capture request and start bucket read
    logic commit;    // apply update and capture result
  } hkv_cmd_t;

  // Bucket index for a key under a key mode.
  function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [1:0] mode,
                                                       input logic [63:0] k);
    logic [31:0] h;
    begin
      h = k[31:0];
      if (mode == MODE_PTR) begin
        h = (HASH_SEED << 5) + HASH_SEED + k[31:0];
        h = (h << 5) + h + k[63:32];
      end
      return h[BUCKET_BITS-1:0];
    end
  endfunction
endpackage

@@ rtl/hash_key_value_store_core.sv @@
// Hash key-value store core: one request at a time, get / set / erase.
// After accept the bucket row is read, then the update is committed and the result word registered.
// A new request is taken only when idle, after the last result word is taken; the
// single-port bucket RAM read-modify-write serves one request at a time.
// Reset (rst, synchronous): valid map, internal entry count, key_mode and controller state cleared.
module hash_key_value_store_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] read_value,
  output logic [8:0]  entry_count
);
  import hkv_pkg::*;

  hkv_cmd_t   cmd;
  logic [1:0] key_mode;

  // Hold the key mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= MODE_U32;
    end else if (cfg_we) begin
      key_mode <= cfg_wdata;
    end
  end

  hkv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  hkv_datapath u_dp (
    .clk(clk), .rst(rst), .key_mode(key_mode), .cmd(cmd),
    .operation(operation), .key(key), .value(value),
    .status(status), .read_value(read_value), .entry_count(entry_count)
  );
endmodule

@@ rtl/hkv_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module hkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first port, read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/hkv_datapath.sv @@
// Datapath: request registers, bucket row RAM, valid map, way compare, result.
// Depends on hkv_pkg and hkv_ram.
module hkv_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   key_mode,
  input  hkv_pkg::hkv_cmd_t            cmd,
  input  logic [1:0]                   operation,
  input  logic [63:0]                  key,
  input  logic [31:0]                  value,
  output logic [1:0]                   status,
  output logic [31:0]                  read_value,
  output logic [8:0]                   entry_count
);
  import hkv_pkg::*;

  localparam int SLOT_BITS = KEY_BITS + VALUE_WIDTH;

  logic [1:0]                  req_op;
  logic [63:0]                 req_key;
  logic [VALUE_WIDTH-1:0]      req_val;
  logic [1:0]                  req_mode;
  logic [BUCKET_BITS-1:0]      req_bucket;
  logic [WAYS_PER_BUCKET-1:0]  valid_map [BUCKET_COUNT];
  logic [WAYS_PER_BUCKET-1:0]  row_valid;
  logic [ROW_BITS-1:0]         row_rd;
  logic [ROW_BITS-1:0]         row_wr;
  logic                        row_we;
  logic [BUCKET_BITS-1:0]      ram_addr;
  logic [COUNT_BITS-1:0]       live;
  logic [WAYS_PER_BUCKET-1:0]  hit_vec;
  logic [WAYS_PER_BUCKET-1:0]  valid_next;
  logic                        hit;
  logic                        free;
  logic [WAY_BITS-1:0]         hit_way;
  logic [WAY_BITS-1:0]         free_way;
  logic [1:0]                  st_next;
  logic [31:0]                 rv_next;
  logic [COUNT_BITS-1:0]       live_next;

  // Address the row by the incoming key on load, by the held bucket on commit
  assign ram_addr = cmd.load ? bucket_of(key_mode, key) : req_bucket;

  hkv_ram #(.WIDTH(ROW_BITS), .DEPTH(BUCKET_COUNT)) u_row_ram (
    .clk(clk), .we(row_we), .addr(ram_addr), .wdata(row_wr), .rdata(row_rd)
  );

  // Hold the request and register the bucket's valid bits with the row read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op <= operation;
      req_key <= key;
      req_val <= value[VALUE_WIDTH-1:0];
      req_mode <= key_mode;
      req_bucket <= bucket_of(key_mode, key);
      row_valid <= valid_map[bucket_of(key_mode, key)];
    end
  end

  // Compare all ways and pick lowest hit and lowest free way
  always_comb begin
    logic [63:0] sk;
    hit = 1'b0;
    free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      sk = row_rd[w*SLOT_BITS + VALUE_WIDTH +: KEY_BITS];
      if (req_mode == MODE_U64 || req_mode == MODE_PTR) begin
        hit_vec[w] = row_valid[w] && (sk == req_key);
      end else begin
        hit_vec[w] = row_valid[w] && (sk[31:0] == req_key[31:0]);
      end
    end
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!row_valid[w]) begin
        free = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  // Build the update and the result
  always_comb begin
    row_wr = row_rd;
    row_we = 1'b0;
    valid_next = row_valid;
    live_next = live;
    st_next = ST_MISS;
    rv_next = '0;
    unique case (req_op)
      OP_GET: begin
        if (hit) begin
          st_next = ST_HIT;
          rv_next = 32'(row_rd[32'(hit_way)*SLOT_BITS +: VALUE_WIDTH]);
        end
      end
      OP_SET: begin
        if (hit || free) begin
          row_we = cmd.commit;
          row_wr[32'(hit ? hit_way : free_way)*SLOT_BITS +: SLOT_BITS] = {req_key, req_val};
          rv_next = 32'(req_val);
          if (hit) begin
            st_next = ST_HIT;
          end else begin
            st_next = ST_INSERTED;
            valid_next[free_way] = 1'b1;
            live_next = live + 1'b1;
          end
        end else begin
          st_next = ST_FULL;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          st_next = ST_HIT;
          valid_next[hit_way] = 1'b0;
          if (live != '0) begin
            live_next = live - 1'b1;
          end
        end
      end
      default: begin
        st_next = ST_MISS;
      end
    endcase
  end

  // Commit valid map, count and result
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        valid_map[b] <= '0;
      end
    end else if (cmd.commit) begin
      live <= live_next;
      valid_map[req_bucket] <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= st_next;
      read_value <= rv_next;
      entry_count <= live_next;
    end
  end
endmodule

@@ rtl/hkv_ctrl.sv @@
// Controller: accepts a word, sequences read then commit, holds the result word.
// Depends on hkv_pkg.
module hkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hkv_pkg::hkv_cmd_t cmd
);
  import hkv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load = in_valid && in_ready;
  assign cmd.commit = (state == S_READ);

  // Advance through read, commit and result hold
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        state_next = S_READ;
      end
      S_READ: state_next = S_OUT;
      S_OUT: if (out_ready) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ rtl/hkv_checker.sv @@
// Port-level checks for the hash key-value store core.
// Depends on hkv_pkg; bound to hash_key_value_store_core.
module hkv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] read_value,
  input logic [8:0]  entry_count
);
  import hkv_pkg::*;

  // No new word taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // A result follows an accepted word after the read and commit states
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ##1 out_valid) else $error("result late");

  // Miss and full carry a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_MISS || status == ST_FULL)) |-> read_value == '0)
    else $error("nonzero value on miss or full");

  // Count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 9'(BUCKET_COUNT * WAYS_PER_BUCKET))
    else $error("entry count out of range");
endmodule

bind hash_key_value_store_core hkv_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .read_value(read_value), .entry_count(entry_count)
);
